FILE: design/cbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants, types and helpers of the cubic curve flattener.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int SEG_LOG2 = 4;
    localparam int SEGMENTS = 1 << SEG_LOG2;
    localparam int COORD_W  = 24;
    localparam int IDX_W    = 4;
    localparam int FRAC_SH  = 3 * SEG_LOG2;
    localparam int ACC_W    = COORD_W + FRAC_SH + 4;
    localparam int COEF_W   = COORD_W + 4;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic [SEG_LOG2-1:0]       t_cnt;
    typedef logic [IDX_W-1:0]          t_idx;

    localparam t_cnt LAST_CNT   = t_cnt'(SEGMENTS - 1);
    localparam t_acc ROUND_HALF = t_acc'(1) << (FRAC_SH - 1);

    // biased first control point and polynomial coefficients of one axis
    typedef struct packed {
        t_coef b0;
        t_coef a;
        t_coef b;
        t_coef c;
    } t_axis_coef;

    typedef struct packed {
        t_axis_coef x;
        t_axis_coef y;
    } t_coef_pair;

    // forward differences of one axis, scaled by SEGMENTS cubed
    typedef struct packed {
        t_acc f;
        t_acc d1;
        t_acc d2;
        t_acc d3;
    } t_axis_diff;

    typedef struct packed {
        t_axis_diff x;
        t_axis_diff y;
    } t_init;

    typedef struct packed {
        t_acc sx;
        t_acc sy;
        t_acc ex;
        t_acc ey;
        t_idx idx;
        logic last;
    } t_seg_raw;

    function automatic t_coef to_biased(input t_coord p);
        return t_coef'($signed({1'b0, ~p[COORD_W-1], p[COORD_W-2:0]}));
    endfunction

    function automatic t_coord round_coord(input t_acc f);
        t_acc                 s;
        logic [COORD_W-1:0]   q;
        s = f + ROUND_HALF;
        q = s[FRAC_SH +: COORD_W];
        return t_coord'({~q[COORD_W-1], q[COORD_W-2:0]});
    endfunction

endpackage

FILE: design/cbf_curve_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_curve_if
// Input channel: one cubic curve as four 2-D control points per word.
// ----------------------------------------------------------------------------
interface cbf_curve_if;
    import cbf_pkg::*;

    logic   valid;
    logic   ready;
    t_coord p0_x;
    t_coord p0_y;
    t_coord p1_x;
    t_coord p1_y;
    t_coord p2_x;
    t_coord p2_y;
    t_coord p3_x;
    t_coord p3_y;

    modport source (
        output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        input  ready
    );
    modport sink (
        input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
        output ready
    );
endinterface

FILE: design/cbf_seg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_seg_if
// Output channel: one line segment of the flattened curve per word.
// ----------------------------------------------------------------------------
interface cbf_seg_if;
    import cbf_pkg::*;

    logic   valid;
    logic   ready;
    t_coord seg_start_x;
    t_coord seg_start_y;
    t_coord seg_end_x;
    t_coord seg_end_y;
    t_idx   seg_index;
    logic   last_segment;

    modport source (
        output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
               seg_index, last_segment,
        input  ready
    );
    modport sink (
        input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
               seg_index, last_segment,
        output ready
    );
endinterface

FILE: design/cbf_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_setup
// Two-stage pipeline from control points to initial forward differences.
// ----------------------------------------------------------------------------
module cbf_setup (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cbf_curve_if.sink      i_curve,
    output logic           o_valid,
    output cbf_pkg::t_init o_init,
    input  logic           i_take
);
    import cbf_pkg::*;

    function automatic t_axis_coef axis_coef(input t_coord p0, input t_coord p1,
                                             input t_coord p2, input t_coord p3);
        t_axis_coef r;
        t_coef      b0, b1, b2, b3;
        b0 = to_biased(p0);
        b1 = to_biased(p1);
        b2 = to_biased(p2);
        b3 = to_biased(p3);
        r.b0 = b0;
        r.a  = b1 - b0;
        r.b  = b0 - (b1 <<< 1) + b2;
        r.c  = b3 - (b2 <<< 1) - b2 + (b1 <<< 1) + b1 - b0;
        return r;
    endfunction

    function automatic t_axis_diff axis_diff(input t_axis_coef k);
        t_axis_diff r;
        t_acc       ea, eb, ec, aa, bb, cc6;
        ea  = t_acc'(k.a);
        eb  = t_acc'(k.b);
        ec  = t_acc'(k.c);
        aa  = (ea <<< (2 * SEG_LOG2 + 1)) + (ea <<< (2 * SEG_LOG2));
        bb  = (eb <<< (SEG_LOG2 + 1)) + (eb <<< SEG_LOG2);
        cc6 = (ec <<< 2) + (ec <<< 1);
        r.f  = t_acc'(k.b0) <<< FRAC_SH;
        r.d1 = aa + bb + ec;
        r.d2 = (bb <<< 1) + cc6;
        r.d3 = cc6;
        return r;
    endfunction

    logic       r_v1, r_v2;
    t_coef_pair r_coef;
    t_init      r_init;
    logic       w_adv1, w_adv2;

    assign w_adv2        = !r_v2 || i_take;
    assign w_adv1        = !r_v1 || w_adv2;
    assign i_curve.ready = w_adv1;
    assign o_valid       = r_v2;
    assign o_init        = r_init;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_curve.valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
        end
        if (w_adv1) begin
            r_coef.x <= axis_coef(i_curve.p0_x, i_curve.p1_x, i_curve.p2_x, i_curve.p3_x);
            r_coef.y <= axis_coef(i_curve.p0_y, i_curve.p1_y, i_curve.p2_y, i_curve.p3_y);
        end
        if (w_adv2) begin
            r_init.x <= axis_diff(r_coef.x);
            r_init.y <= axis_diff(r_coef.y);
        end
    end

endmodule

FILE: design/cbf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_cell
// One forward-difference cell: loads a start value, then adds its neighbor.
// ----------------------------------------------------------------------------
module cbf_cell (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_step,
    input  cbf_pkg::t_acc i_init,
    input  cbf_pkg::t_acc i_nbr,
    output cbf_pkg::t_acc o_val
);
    import cbf_pkg::*;

    t_acc r_val, n_val;

    always_comb begin
        n_val = r_val;
        if (i_load) begin
            n_val = i_init;
        end else if (i_step) begin
            n_val = r_val + i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

FILE: design/cbf_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_stepper
// Row of difference cells per axis, stepped once per segment, with counter.
// ----------------------------------------------------------------------------
module cbf_stepper (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_init_valid,
    input  cbf_pkg::t_init    i_init,
    output logic              o_init_take,
    input  logic              i_out_free,
    output logic              o_seg_valid,
    output cbf_pkg::t_seg_raw o_seg
);
    import cbf_pkg::*;

    localparam int NCELL = 4;

    logic r_busy;
    t_cnt r_cnt;
    logic w_step, w_last, w_load;
    t_acc w_init [2][NCELL];
    t_acc w_val  [2][NCELL];

    assign w_step = r_busy && i_out_free;
    assign w_last = (r_cnt == LAST_CNT);
    assign w_load = i_init_valid && (!r_busy || (w_step && w_last));
    assign o_init_take = w_load;

    assign w_init[0][0] = i_init.x.f;
    assign w_init[0][1] = i_init.x.d1;
    assign w_init[0][2] = i_init.x.d2;
    assign w_init[0][3] = i_init.x.d3;
    assign w_init[1][0] = i_init.y.f;
    assign w_init[1][1] = i_init.y.d1;
    assign w_init[1][2] = i_init.y.d2;
    assign w_init[1][3] = i_init.y.d3;

    for (genvar g_ax = 0; g_ax < 2; g_ax++) begin : g_axis
        for (genvar g_k = 0; g_k < NCELL; g_k++) begin : g_row
            t_acc w_nbr;
            if (g_k == NCELL - 1) begin : g_end
                assign w_nbr = '0;
            end else begin : g_mid
                assign w_nbr = w_val[g_ax][g_k+1];
            end
            cbf_cell u_cell (
                .i_clk  (i_clk),
                .i_load (w_load),
                .i_step (w_step),
                .i_init (w_init[g_ax][g_k]),
                .i_nbr  (w_nbr),
                .o_val  (w_val[g_ax][g_k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_step) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_seg_valid = w_step;
    assign o_seg.sx    = w_val[0][0];
    assign o_seg.sy    = w_val[1][0];
    assign o_seg.ex    = w_val[0][0] + w_val[0][1];
    assign o_seg.ey    = w_val[1][0] + w_val[1][1];
    assign o_seg.idx   = t_idx'(r_cnt);
    assign o_seg.last  = w_last;

    a_load_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_busy && r_cnt == '0))
        else $error("stepper did not restart on load");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_last && !i_init_valid) |=> !r_busy)
        else $error("stepper busy after last segment");

    a_cubic_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_load) |=> ($stable(w_val[0][3]) && $stable(w_val[1][3])))
        else $error("third difference changed inside a curve");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |-> (!o_seg.sx[ACC_W-1] && !o_seg.ex[ACC_W-1]
                    && !o_seg.sy[ACC_W-1] && !o_seg.ey[ACC_W-1]))
        else $error("sample left the convex hull range");

endmodule

FILE: design/cubic_bezier_flattener.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Cubic curve to line segments, sampled at SEGMENTS even steps of t.
//
// i_curve takes one word per curve: four control points, signed 24-bit
// coordinates with 8 fraction bits. o_seg gives SEGMENTS words per curve,
// each a segment from sample i to sample i+1 (rounded half up), its index
// and a flag on the final one.
// The first segment passes the two setup stages, the difference cells and
// the output register. While o_seg does not stall: one segment per cycle,
// set by the row of difference cells that advances one sample per cycle;
// the next curve waits in the two-stage setup pipeline and loads as the
// last segment leaves, so curves follow each other with no gap.
// Reset clears all valid flags; nothing else needs clearing.
// When o_seg stalls, the output register holds its word, the cells stop, and
// i_curve stays ready until the setup pipeline is full.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbf_curve_if.sink i_curve,
    cbf_seg_if.source o_seg
);
    import cbf_pkg::*;

    logic     w_init_valid, w_init_take;
    t_init    w_init;
    logic     w_seg_valid, w_out_free;
    t_seg_raw w_seg;

    logic   r_out_valid;
    t_coord r_sx, r_sy, r_ex, r_ey;
    t_idx   r_idx;
    logic   r_last;

    cbf_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_curve (i_curve),
        .o_valid (w_init_valid),
        .o_init  (w_init),
        .i_take  (w_init_take)
    );

    cbf_stepper u_stepper (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init_valid (w_init_valid),
        .i_init       (w_init),
        .o_init_take  (w_init_take),
        .i_out_free   (w_out_free),
        .o_seg_valid  (w_seg_valid),
        .o_seg        (w_seg)
    );

    assign w_out_free = !r_out_valid || o_seg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_seg_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_seg.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_seg_valid) begin
            r_sx   <= round_coord(w_seg.sx);
            r_sy   <= round_coord(w_seg.sy);
            r_ex   <= round_coord(w_seg.ex);
            r_ey   <= round_coord(w_seg.ey);
            r_idx  <= w_seg.idx;
            r_last <= w_seg.last;
        end
    end

    assign o_seg.valid        = r_out_valid;
    assign o_seg.seg_start_x  = r_sx;
    assign o_seg.seg_start_y  = r_sy;
    assign o_seg.seg_end_x    = r_ex;
    assign o_seg.seg_end_y    = r_ey;
    assign o_seg.seg_index    = r_idx;
    assign o_seg.last_segment = r_last;

endmodule

FILE: dv/cbf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_checker
// Watches both channels of the curve flattener and checks every segment.
//
// Each accepted curve is sampled at t = i/SEGMENTS in exact Bernstein form
// with integer weights, on biased (unsigned) coordinates, and rounded half
// up. The segments expected from those samples wait in order. Every segment
// word taken from the output is compared field by field with the oldest
// one. Mismatches, unexpected words and the count still waiting go to the
// top level.
// ----------------------------------------------------------------------------
module cbf_checker
    import cbf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    cbf_curve_if  i_curve,
    cbf_seg_if    i_seg,
    output int    o_fail_count,
    output int    o_pending
);

    localparam logic [COORD_W-1:0] COORD_MSB = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
        t_idx   idx;
        logic   last;
    } t_seg_word;

    t_seg_word segs_due_q[$];
    int        mismatch_count = 0;

    // one coordinate of the curve at t = i/SEGMENTS
    function automatic t_coord curve_sample(input t_coord c0, c1, c2, c3,
                                            input int unsigned i);
        t_coord             pts [4];
        longint unsigned    w [4];
        longint unsigned    n;
        longint unsigned    j;
        longint unsigned    d;
        longint unsigned    acc;
        longint unsigned    q;
        logic [COORD_W-1:0] b;
        pts[0] = c0;
        pts[1] = c1;
        pts[2] = c2;
        pts[3] = c3;
        n      = SEGMENTS;
        j      = n - i;
        d      = n * n * n;
        w[0]   = j * j * j;
        w[1]   = 3 * j * j * i;
        w[2]   = 3 * j * i * i;
        w[3]   = longint'(i) * i * i;
        acc    = 0;
        for (int k = 0; k < 4; k++) begin
            b   = pts[k] ^ COORD_MSB;
            acc = acc + w[k] * b;
        end
        q = (2 * acc + d) / (2 * d);
        return t_coord'(q[COORD_W-1:0] ^ COORD_MSB);
    endfunction

    task automatic compare_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_coord    xs [SEGMENTS+1];
        t_coord    ys [SEGMENTS+1];
        t_seg_word want;
        if (i_rst_n && i_curve.valid && i_curve.ready) begin
            for (int i = 0; i <= SEGMENTS; i++) begin
                xs[i] = curve_sample(i_curve.p0_x, i_curve.p1_x, i_curve.p2_x,
                                     i_curve.p3_x, i);
                ys[i] = curve_sample(i_curve.p0_y, i_curve.p1_y, i_curve.p2_y,
                                     i_curve.p3_y, i);
            end
            for (int i = 0; i < SEGMENTS; i++) begin
                want.sx   = xs[i];
                want.sy   = ys[i];
                want.ex   = xs[i+1];
                want.ey   = ys[i+1];
                want.idx  = t_idx'(i);
                want.last = (i == SEGMENTS - 1);
                segs_due_q.push_back(want);
            end
        end
        if (i_rst_n && i_seg.valid && i_seg.ready) begin
            if (segs_due_q.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: segment word with none expected, expected none, actual index %0d",
                         $time, i_seg.seg_index);
            end else begin
                want = segs_due_q.pop_front();
                compare_field("seg_start_x", want.sx, i_seg.seg_start_x);
                compare_field("seg_start_y", want.sy, i_seg.seg_start_y);
                compare_field("seg_end_x", want.ex, i_seg.seg_end_x);
                compare_field("seg_end_y", want.ey, i_seg.seg_end_y);
                compare_field("seg_index", want.idx, i_seg.seg_index);
                compare_field("last_segment", want.last, i_seg.last_segment);
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= segs_due_q.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the cubic curve flattener.
//
// A directed set of curves (extreme, degenerate and rounding-tie cases) is
// followed by a full drain and then by random curves whose coordinates mix
// full-range values, extremes and small values near zero. The sender and the
// segment receiver both stall at random, except in one calm stretch. The
// checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
    import cbf_pkg::*;

    localparam int     RANDOM_CURVES = 348;
    localparam int     IDLE_PCT      = 18;
    localparam int     WATCHDOG_MAX  = 2000;
    localparam int     DRAIN_CYCLES  = 8;
    localparam t_coord CMIN          = t_coord'(24'h800000);
    localparam t_coord CMAX          = t_coord'(24'h7FFFFF);
    localparam t_coord PAT_A         = t_coord'(24'h555555);
    localparam t_coord PAT_B         = t_coord'(24'hAAAAAA);

    typedef struct packed {
        t_coord p0_x;
        t_coord p0_y;
        t_coord p1_x;
        t_coord p1_y;
        t_coord p2_x;
        t_coord p2_y;
        t_coord p3_x;
        t_coord p3_y;
    } t_curve;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   fail_count;
    int   pending_segs;
    int   quiet_cycles = 0;

    cbf_curve_if curve_ch ();
    cbf_seg_if   seg_ch ();

    cubic_bezier_flattener dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_curve (curve_ch),
        .o_seg   (seg_ch)
    );

    cbf_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_curve      (curve_ch),
        .i_seg        (seg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_segs)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // segment receiver stalls
    always @(posedge i_clk) begin
        seg_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((curve_ch.valid && curve_ch.ready) || (seg_ch.valid && seg_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic t_coord pick_coord();
        case ($urandom_range(9))
            0:       return CMIN;
            1:       return CMAX;
            2, 3:    return t_coord'(int'($urandom_range(8)) - 4);
            default: return t_coord'($urandom);
        endcase
    endfunction

    task automatic send_curve(input t_curve c);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                curve_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            if ($urandom_range(99) < 3) begin
                curve_ch.valid <= 1'b0;
                repeat ($urandom_range(40, 1)) @(posedge i_clk);
            end
        end
        curve_ch.valid <= 1'b1;
        curve_ch.p0_x  <= c.p0_x;
        curve_ch.p0_y  <= c.p0_y;
        curve_ch.p1_x  <= c.p1_x;
        curve_ch.p1_y  <= c.p1_y;
        curve_ch.p2_x  <= c.p2_x;
        curve_ch.p2_y  <= c.p2_y;
        curve_ch.p3_x  <= c.p3_x;
        curve_ch.p3_y  <= c.p3_y;
        do @(posedge i_clk); while (!curve_ch.ready);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_segs != 0);
    endtask

    initial begin
        t_curve c;
        i_rst_n        = 1'b0;
        calm           = 1'b0;
        curve_ch.valid = 1'b0;
        curve_ch.p0_x  = '0;
        curve_ch.p0_y  = '0;
        curve_ch.p1_x  = '0;
        curve_ch.p1_y  = '0;
        curve_ch.p2_x  = '0;
        curve_ch.p2_y  = '0;
        curve_ch.p3_x  = '0;
        curve_ch.p3_y  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed curves
        send_curve('{'0, '0, '0, '0, '0, '0, '0, '0});
        send_curve('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX});
        send_curve('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN});
        send_curve('{CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, CMIN});
        send_curve('{CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN});
        // rounding ties around zero
        send_curve('{t_coord'(1), t_coord'(-1), '0, '0, '0, '0, '0, '0});
        send_curve('{'0, '0, '0, '0, '0, '0, t_coord'(1), t_coord'(-1)});
        send_curve('{'0, '0, t_coord'(1), '0, '0, t_coord'(-1), '0, '0});
        // straight line, evenly spaced points
        send_curve('{'0, '0, t_coord'(256), t_coord'(-256), t_coord'(512),
                     t_coord'(-512), t_coord'(768), t_coord'(-768)});
        send_curve('{CMAX, t_coord'(-1), CMAX, CMIN, CMIN, CMAX, CMIN, '0});
        send_curve('{PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B});
        send_curve('{PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A, PAT_B, PAT_A});

        // let every segment out before the random part
        curve_ch.valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_CURVES; n++) begin
            calm   = (n >= 120 && n < 200);
            c.p0_x = pick_coord();
            c.p0_y = pick_coord();
            c.p1_x = pick_coord();
            c.p1_y = pick_coord();
            c.p2_x = pick_coord();
            c.p2_y = pick_coord();
            c.p3_x = pick_coord();
            c.p3_y = pick_coord();
            send_curve(c);
        end
        curve_ch.valid <= 1'b0;
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_segs == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/cbf_pkg.sv
design/cbf_curve_if.sv
design/cbf_seg_if.sv
design/cbf_setup.sv
design/cbf_cell.sv
design/cbf_stepper.sv
design/cubic_bezier_flattener.sv
dv/cbf_checker.sv
dv/testbench.sv
